### hw/rtl/fge_pkg.sv
// Shared types, character codes and the 5x7 font for the glyph square expander.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fge_pkg;

	localparam int unsigned DOTS = 35;   // 5 columns of 7 rows
	localparam int unsigned ROWS = 7;
	localparam int unsigned PCT_DOTS = 9;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_LESS    = 8'h3C;
	localparam logic [7:0] CHAR_GREATER = 8'h3E;
	localparam logic [7:0] CHAR_QUEST   = 8'h3F;
	localparam logic [7:0] CHAR_EXCLAIM = 8'h21;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic done;
	} dp_stat_t;

	typedef struct packed {
		logic            valid;
		logic [DOTS-1:0] dots;
	} glyph_t;

	typedef struct packed {
		logic [2:0] col;
		logic [2:0] row;
	} dot_pos_t;

	// Column bytes are listed column 0 first; bit r of a byte is row r.
	function automatic logic [39:0] fge_digit(input logic [3:0] idx);
		logic [39:0] g;
		case (idx)
			4'd0: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
			4'd1: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			4'd2: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			4'd3: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
			4'd4: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			4'd5: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			4'd6: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			4'd7: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			4'd8: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			4'd9: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			default: g = '0;
		endcase
		return g;
	endfunction

	function automatic logic [39:0] fge_letter(input logic [4:0] idx);
		logic [39:0] g;
		case (idx)
			5'd0:  g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
			5'd1:  g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
			5'd2:  g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
			5'd3:  g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
			5'd4:  g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
			5'd5:  g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
			5'd6:  g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
			5'd7:  g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
			5'd8:  g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
			5'd9:  g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
			5'd10: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
			5'd11: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
			5'd12: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
			5'd13: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
			5'd14: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
			5'd15: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
			5'd16: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
			5'd17: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
			5'd18: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			5'd19: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
			5'd20: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
			5'd21: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
			5'd22: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
			5'd23: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
			5'd24: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
			5'd25: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
			default: g = '0;
		endcase
		return g;
	endfunction

	// Font lookup: valid is low for space, percent and every unmapped code.
	function automatic glyph_t fge_glyph(input logic [7:0] code);
		glyph_t      r;
		logic [39:0] g;
		logic        v;
		v = 1'b1;
		g = '0;
		if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
			g = fge_digit(4'(code - CHAR_ZERO));
		end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
			g = fge_letter(5'(code - CHAR_UPPER_A));
		end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
			g = fge_letter(5'(code - CHAR_LOWER_A));
		end else begin
			case (code)
				CHAR_PERIOD:  g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
				CHAR_MINUS:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
				CHAR_COLON:   g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
				CHAR_EXCLAIM: g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
				CHAR_QUEST:   g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
				CHAR_SLASH:   g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
				CHAR_PLUS:    g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
				CHAR_LESS:    g = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
				CHAR_GREATER: g = {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
				default:      v = 1'b0;
			endcase
		end
		r.valid = v;
		// Pack column-major so that bit col*7+row is the dot at (col, row).
		for (int c = 0; c < 5; c++) begin
			r.dots[c*ROWS +: ROWS] = g[(4-c)*8 +: ROWS];
		end
		return r;
	endfunction

	// Dot order of the percent sign: two corner dots, then the diagonal.
	function automatic dot_pos_t fge_pct_dot(input logic [3:0] idx);
		dot_pos_t p;
		case (idx)
			4'd0: p = '{col: 3'd0, row: 3'd0};
			4'd1: p = '{col: 3'd4, row: 3'd6};
			4'd2: p = '{col: 3'd4, row: 3'd0};
			4'd3: p = '{col: 3'd4, row: 3'd1};
			4'd4: p = '{col: 3'd3, row: 3'd2};
			4'd5: p = '{col: 3'd2, row: 3'd3};
			4'd6: p = '{col: 3'd2, row: 3'd4};
			4'd7: p = '{col: 3'd1, row: 3'd5};
			4'd8: p = '{col: 3'd0, row: 3'd6};
			default: p = '{col: 3'd0, row: 3'd0};
		endcase
		return p;
	endfunction

endpackage

### hw/rtl/font_glyph_square_expander.sv
// Top level of the 5x7 font glyph square expander.
// Depends on fge_pkg, fge_ctrl and fge_datapath.
//
//   channel   handshake             payload
//   --------  --------------------  ---------------------------------------------
//   command   start / busy          char_code, origin_x, origin_y, colour, scale
//   squares   square_valid strobe   square_x, square_y, square_side,
//                                   square_colour, last_square
//
// A command word is taken at a rising edge with start high and busy low and is
// captured at that same edge. The block then stays busy through the font lookup
// and walks the dot shift register at one dot per cycle, through the last lit
// dot of a font glyph or the nine dots of the percent sign. An empty item (zero
// scale, or an unmapped code) goes back to idle from the lookup state. No new
// word is accepted until the scan of the last one is through.
// Each square appears for one cycle, in the cycle after its dot is scanned; the
// receiver cannot stall, so nothing waits on it. The next command may already
// be accepted while the final square of the previous one is on the ports.
// Reset is asynchronous and active low; it clears the state machine and the
// strobe, so no square is shown until a command arrives.
module font_glyph_square_expander (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         char_code,
	input  logic signed [11:0] origin_x,
	input  logic signed [11:0] origin_y,
	input  logic [15:0]        colour,
	input  logic [3:0]         scale,
	output logic               square_valid,
	output logic signed [12:0] square_x,
	output logic signed [12:0] square_y,
	output logic [3:0]         square_side,
	output logic [15:0]        square_colour,
	output logic               last_square
);

	// Commands go from the controller to the datapath; status comes back.
	fge_pkg::ctrl_cmd_t cmd;
	fge_pkg::dp_stat_t  stat;

	fge_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath also owns the result register, so squares leave the block
	// straight from flip-flops.
	fge_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.char_code     (char_code),
		.origin_x      (origin_x),
		.origin_y      (origin_y),
		.colour        (colour),
		.scale         (scale),
		.square_valid  (square_valid),
		.square_x      (square_x),
		.square_y      (square_y),
		.square_side   (square_side),
		.square_colour (square_colour),
		.last_square   (last_square)
	);

endmodule

### hw/rtl/fge_ctrl.sv
// Controller state machine of the glyph square expander.
// Depends on fge_pkg for the state, command and status types.
module fge_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fge_pkg::dp_stat_t  stat,
	output fge_pkg::ctrl_cmd_t cmd,
	output logic               busy
);

	fge_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fge_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			fge_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = fge_pkg::ST_LOOK;
				end
			end
			fge_pkg::ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = stat.empty ? fge_pkg::ST_IDLE : fge_pkg::ST_SCAN;
			end
			fge_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.done) begin
					state_d = fge_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fge_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/fge_datapath.sv
// Datapath of the glyph square expander: captured word, dot shift register,
// dot position counters, coordinate arithmetic and the result register.
// Depends on fge_pkg for the font, the percent dot table and the shared types.
module fge_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  fge_pkg::ctrl_cmd_t  cmd,
	output fge_pkg::dp_stat_t   stat,
	input  logic [7:0]          char_code,
	input  logic signed [11:0]  origin_x,
	input  logic signed [11:0]  origin_y,
	input  logic [15:0]         colour,
	input  logic [3:0]          scale,
	output logic                square_valid,
	output logic signed [12:0]  square_x,
	output logic signed [12:0]  square_y,
	output logic [3:0]          square_side,
	output logic [15:0]         square_colour,
	output logic                last_square
);

	logic [7:0]                  char_q;
	logic signed [11:0]          ox_q, oy_q;
	logic [15:0]                 colour_q;
	logic [3:0]                  scale_q;
	logic [fge_pkg::DOTS-1:0]    bits_q;
	logic                        pct_q;
	logic [2:0]                  col_q, row_q;
	logic [3:0]                  idx_q;
	logic                        strobe_q;
	logic signed [12:0]          square_x_q, square_y_q;
	logic [3:0]                  square_side_q;
	logic [15:0]                 square_colour_q;
	logic                        last_square_q;

	fge_pkg::glyph_t   glyph;
	fge_pkg::dot_pos_t pct_pos;
	logic              is_pct;
	logic [2:0]        cur_col, cur_row;
	logic [6:0]        x_off, y_off;
	logic              remaining_zero;

	assign glyph   = fge_pkg::fge_glyph(char_q);
	assign is_pct  = (char_q == fge_pkg::CHAR_PERCENT);
	assign pct_pos = fge_pkg::fge_pct_dot(idx_q);

	assign stat.empty = (scale_q == 4'd0) || (!glyph.valid && !is_pct);
	assign remaining_zero = (bits_q[fge_pkg::DOTS-1:1] == '0);
	assign stat.done  = remaining_zero;

	assign cur_col = pct_q ? pct_pos.col : col_q;
	assign cur_row = pct_q ? pct_pos.row : row_q;
	assign x_off   = 7'(cur_col) * 7'(scale_q);
	assign y_off   = 7'(cur_row) * 7'(scale_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q   <= char_code;
			ox_q     <= origin_x;
			oy_q     <= origin_y;
			colour_q <= colour;
			scale_q  <= scale;
		end
		if (cmd.lookup) begin
			pct_q  <= is_pct;
			bits_q <= is_pct ? fge_pkg::DOTS'({fge_pkg::PCT_DOTS{1'b1}}) : glyph.dots;
			col_q  <= '0;
			row_q  <= '0;
			idx_q  <= '0;
		end else if (cmd.step) begin
			bits_q <= bits_q >> 1;
			if (pct_q) begin
				idx_q <= idx_q + 4'd1;
			end else if (row_q == 3'(fge_pkg::ROWS - 1)) begin
				row_q <= '0;
				col_q <= col_q + 3'd1;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
		if (cmd.step) begin
			square_x_q      <= 13'(ox_q) + 13'(x_off);
			square_y_q      <= 13'(oy_q) + 13'(y_off);
			square_side_q   <= scale_q;
			square_colour_q <= colour_q;
			last_square_q   <= remaining_zero;
		end
	end

	// Only the strobe needs a reset; the payload is qualified by it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step && bits_q[0];
		end
	end

	assign square_valid  = strobe_q;
	assign square_x      = square_x_q;
	assign square_y      = square_y_q;
	assign square_side   = square_side_q;
	assign square_colour = square_colour_q;
	assign last_square   = last_square_q;

endmodule

### sim/font_glyph_square_expander_test.sv
// Self-checking testbench for font_glyph_square_expander: character words go in, square words
// come out and are compared against a font predictor written here. Depends on fge_pkg and the RTL.
module font_glyph_square_expander_test;

	// Codes used by the stimulus that the package does not name.
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CODE_HIGH_LO = 8'h80;
	localparam logic [7:0] CODE_HIGH_HI = 8'hFF;
	localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
	localparam logic [7:0] CHAR_EIGHT   = 8'h38;
	localparam logic [7:0] CHAR_UPPER_B = 8'h42;

	localparam int CYCLE_LIMIT = 100000;
	// Cycles to keep watching after the last expected square, covering a full glyph scan.
	localparam int SETTLE_CYCLES = 45;

	typedef struct {
		logic signed [12:0] x;
		logic signed [12:0] y;
		logic [3:0]         side;
		logic [15:0]        fill;
		logic               last;
	} square_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [7:0]         char_code;
	logic signed [11:0] origin_x;
	logic signed [11:0] origin_y;
	logic [15:0]        colour;
	logic [3:0]         scale;
	logic               square_valid;
	logic signed [12:0] square_x;
	logic signed [12:0] square_y;
	logic [3:0]         square_side;
	logic [15:0]        square_colour;
	logic               last_square;

	// Font image: column bytes, column 0 in the top byte; bit r of a byte is row r.
	logic [39:0] glyph_cols [256];
	bit          glyph_known [256];
	logic [7:0]  drawable_codes[$];

	square_t     pending_squares[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	bit          gaps_off = 1'b0;

	font_glyph_square_expander dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.char_code     (char_code),
		.origin_x      (origin_x),
		.origin_y      (origin_y),
		.colour        (colour),
		.scale         (scale),
		.square_valid  (square_valid),
		.square_x      (square_x),
		.square_y      (square_y),
		.square_side   (square_side),
		.square_colour (square_colour),
		.last_square   (last_square)
	);

	always #1 clk = ~clk;

	// The font is filled in at time zero, long before the first word can be accepted.
	// Lower case letters reuse the upper case glyphs.
	initial begin
		for (int i = 0; i < 256; i++) begin
			glyph_cols[i] = '0;
			glyph_known[i] = 1'b0;
		end
		glyph_cols[fge_pkg::CHAR_ZERO + 0] = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
		glyph_cols[fge_pkg::CHAR_ZERO + 1] = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
		glyph_cols[fge_pkg::CHAR_ZERO + 2] = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
		glyph_cols[fge_pkg::CHAR_ZERO + 3] = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
		glyph_cols[fge_pkg::CHAR_ZERO + 4] = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
		glyph_cols[fge_pkg::CHAR_ZERO + 5] = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
		glyph_cols[fge_pkg::CHAR_ZERO + 6] = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
		glyph_cols[fge_pkg::CHAR_ZERO + 7] = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
		glyph_cols[fge_pkg::CHAR_ZERO + 8] = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
		glyph_cols[fge_pkg::CHAR_ZERO + 9] = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 0]  = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 1]  = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 2]  = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 3]  = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 4]  = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 5]  = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 6]  = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 7]  = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 8]  = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 9]  = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 10] = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 11] = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 12] = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 13] = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 14] = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 15] = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 16] = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 17] = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 18] = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 19] = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 20] = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 21] = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 22] = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 23] = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 24] = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
		glyph_cols[fge_pkg::CHAR_UPPER_A + 25] = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
		for (int i = 0; i < 10; i++) begin
			glyph_known[fge_pkg::CHAR_ZERO + i] = 1'b1;
		end
		for (int i = 0; i < 26; i++) begin
			glyph_cols[fge_pkg::CHAR_LOWER_A + i] = glyph_cols[fge_pkg::CHAR_UPPER_A + i];
			glyph_known[fge_pkg::CHAR_UPPER_A + i] = 1'b1;
			glyph_known[fge_pkg::CHAR_LOWER_A + i] = 1'b1;
		end
		glyph_cols[fge_pkg::CHAR_PERIOD]  = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
		glyph_cols[fge_pkg::CHAR_MINUS]   = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
		glyph_cols[fge_pkg::CHAR_COLON]   = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
		glyph_cols[fge_pkg::CHAR_EXCLAIM] = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
		glyph_cols[fge_pkg::CHAR_QUEST]   = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
		glyph_cols[fge_pkg::CHAR_SLASH]   = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
		glyph_cols[fge_pkg::CHAR_PLUS]    = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
		glyph_cols[fge_pkg::CHAR_LESS]    = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
		glyph_cols[fge_pkg::CHAR_GREATER] = {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
		glyph_known[fge_pkg::CHAR_PERIOD]  = 1'b1;
		glyph_known[fge_pkg::CHAR_MINUS]   = 1'b1;
		glyph_known[fge_pkg::CHAR_COLON]   = 1'b1;
		glyph_known[fge_pkg::CHAR_EXCLAIM] = 1'b1;
		glyph_known[fge_pkg::CHAR_QUEST]   = 1'b1;
		glyph_known[fge_pkg::CHAR_SLASH]   = 1'b1;
		glyph_known[fge_pkg::CHAR_PLUS]    = 1'b1;
		glyph_known[fge_pkg::CHAR_LESS]    = 1'b1;
		glyph_known[fge_pkg::CHAR_GREATER] = 1'b1;
		// Codes that draw something, plus space, feed the well-formed random text.
		for (int i = 0; i < 256; i++) begin
			if (glyph_known[i]) begin
				drawable_codes.push_back(8'(i));
			end
		end
		drawable_codes.push_back(fge_pkg::CHAR_PERCENT);
		drawable_codes.push_back(CHAR_SPACE);
	end

	// Works out the squares one accepted word must produce and appends them, in
	// output order, to the store of pending squares. A zero scale, space and
	// every unmapped code produce nothing. The percent sign is two corner dots
	// followed by a seven-step diagonal; every other glyph is scanned column by
	// column with rows 0 to 6 inside each column.
	function automatic void predict_squares(input logic [7:0] code,
			input logic signed [11:0] ox, input logic signed [11:0] oy,
			input logic [15:0] fill, input logic [3:0] side);
		int          dot_col[$];
		int          dot_row[$];
		logic [39:0] cols;
		square_t     sq;
		if (side == 4'd0) begin
			return;
		end
		if (code == fge_pkg::CHAR_PERCENT) begin
			dot_col.push_back(0);
			dot_row.push_back(0);
			dot_col.push_back(4);
			dot_row.push_back(6);
			for (int i = 0; i < 7; i++) begin
				dot_col.push_back(4 - (4 * i) / 6);
				dot_row.push_back(i);
			end
		end else if (glyph_known[code]) begin
			cols = glyph_cols[code];
			for (int c = 0; c < 5; c++) begin
				for (int r = 0; r < 7; r++) begin
					if (cols[(4 - c) * 8 + r]) begin
						dot_col.push_back(c);
						dot_row.push_back(r);
					end
				end
			end
		end
		for (int n = 0; n < dot_col.size(); n++) begin
			// Origin plus 6 * 15 always fits in 13 signed bits, so no wrap is expected.
			sq.x = 13'(int'(ox) + dot_col[n] * int'(side));
			sq.y = 13'(int'(oy) + dot_row[n] * int'(side));
			sq.side = side;
			sq.fill = fill;
			sq.last = (n == dot_col.size() - 1);
			pending_squares.push_back(sq);
		end
	endfunction

	// Checker and predictor trigger in one process on the rising edge. The square
	// on the ports is checked first, so squares from an earlier word always pop
	// ahead of those that a word accepted at this same edge pushes.
	always @(posedge clk) begin
		square_t want;
		if (arst_n) begin
			if (square_valid) begin
				if (pending_squares.size() == 0) begin
					$error("square word at (%0d, %0d) with no square pending",
						square_x, square_y);
					mismatches++;
				end else begin
					want = pending_squares.pop_front();
					if (square_x !== want.x) begin
						$error("square_x expected %0d actual %0d", want.x, square_x);
						mismatches++;
					end
					if (square_y !== want.y) begin
						$error("square_y expected %0d actual %0d", want.y, square_y);
						mismatches++;
					end
					if (square_side !== want.side) begin
						$error("square_side expected %0d actual %0d", want.side, square_side);
						mismatches++;
					end
					if (square_colour !== want.fill) begin
						$error("square_colour expected %h actual %h", want.fill, square_colour);
						mismatches++;
					end
					if (last_square !== want.last) begin
						$error("last_square expected %b actual %b", want.last, last_square);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				predict_squares(char_code, origin_x, origin_y, colour, scale);
			end
		end
	end

	// Watchdog: a hung handshake or a missing square ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one command word and returns once it has been taken. The sender
	// works in bursts: when a burst runs out, start drops for a random gap,
	// sometimes short, sometimes longer than a whole glyph scan, with junk on the
	// payload so that only start qualifies it. Inside a burst start stays high
	// from word to word. Acceptance reads busy right after the edge, which is
	// its value at the edge itself.
	task automatic send_word(input logic [7:0] code, input logic signed [11:0] ox,
			input logic signed [11:0] oy, input logic [15:0] fill, input logic [3:0] side);
		int gap;
		@(negedge clk);
		if (!gaps_off && burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 4);
			if (gap > 0) begin
				start     <= 1'b0;
				char_code <= 8'($urandom);
				origin_x  <= 12'($urandom);
				origin_y  <= 12'($urandom);
				colour    <= 16'($urandom);
				scale     <= 4'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		start     <= 1'b1;
		char_code <= code;
		origin_x  <= ox;
		origin_y  <= oy;
		colour    <= fill;
		scale     <= side;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	// Drops start and holds off until every pending square has come out.
	task automatic wait_for_squares();
		@(negedge clk);
		start <= 1'b0;
		while (pending_squares.size() != 0 || busy) begin
			@(negedge clk);
		end
	endtask

	// One random word. Well-formed text draws from the codes that the font maps;
	// noise takes any byte. Origins lean toward the extremes now and then, and a
	// zero scale turns up rarely.
	task automatic send_random_word(input bit wellformed);
		logic [7:0]         code;
		logic signed [11:0] ox;
		logic signed [11:0] oy;
		logic [3:0]         side;
		if (wellformed) begin
			code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
		end else begin
			code = 8'($urandom);
		end
		case ($urandom_range(0, 5))
			0: ox = -12'sd2048;
			1: ox = 12'sd2047;
			default: ox = 12'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: oy = -12'sd2048;
			1: oy = 12'sd2047;
			default: oy = 12'($urandom);
		endcase
		side = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		send_word(code, ox, oy, 16'($urandom), side);
	endtask

	// Extreme origins, colours and scales on the percent sign, digits and letters
	// of both cases, then every punctuation mark, space, codes above the font
	// range and a zero scale.
	task automatic test_directed_glyphs();
		logic [7:0] marks [9];
		marks = '{fge_pkg::CHAR_PERIOD, fge_pkg::CHAR_MINUS, fge_pkg::CHAR_COLON,
			fge_pkg::CHAR_EXCLAIM, fge_pkg::CHAR_QUEST, fge_pkg::CHAR_SLASH,
			fge_pkg::CHAR_PLUS, fge_pkg::CHAR_LESS, fge_pkg::CHAR_GREATER};
		send_word(fge_pkg::CHAR_PERCENT, -12'sd2048, -12'sd2048, 16'h0000, 4'd15);
		send_word(fge_pkg::CHAR_PERCENT, 12'sd2047, 12'sd2047, 16'hFFFF, 4'd15);
		send_word(CHAR_EIGHT, 12'sd2047, -12'sd2048, 16'hFFFF, 4'd15);
		send_word(fge_pkg::CHAR_ZERO, -12'sd2048, 12'sd2047, 16'h0000, 4'd1);
		send_word(fge_pkg::CHAR_UPPER_A, 12'sd0, 12'sd0, 16'hAAAA, 4'd1);
		send_word(fge_pkg::CHAR_LOWER_Z, 12'sd100, -12'sd100, 16'h5555, 4'd7);
		send_word(CHAR_UPPER_M, -12'sd1, 12'sd1, 16'h8001, 4'd2);
		send_word(fge_pkg::CHAR_NINE, 12'sd1365, -12'sd1366, 16'h7FFE, 4'd8);
		for (int i = 0; i < 9; i++) begin
			send_word(marks[i], 12'($urandom), 12'($urandom), 16'($urandom), 4'(i + 3));
		end
		send_word(CHAR_SPACE, 12'sd10, 12'sd10, 16'h1234, 4'd4);
		send_word(CODE_HIGH_LO, 12'sd10, 12'sd10, 16'h1234, 4'd4);
		send_word(CODE_HIGH_HI, 12'sd10, 12'sd10, 16'h1234, 4'd4);
		send_word(CHAR_UPPER_B, 12'sd5, 12'sd5, 16'hFFFF, 4'd0);
		send_word(fge_pkg::CHAR_PERCENT, 12'sd5, 12'sd5, 16'hFFFF, 4'd0);
		wait_for_squares();
	endtask

	// Words offered back to back with start never dropping, so a word that follows
	// a drawn glyph lands while that glyph's last square is still on the ports.
	task automatic test_back_to_back();
		gaps_off = 1'b1;
		for (int i = 0; i < 20; i++) begin
			send_random_word(1'b1);
		end
		gaps_off = 1'b0;
		wait_for_squares();
	endtask

	// Mostly well-formed text with random content and bursty input.
	task automatic test_random_text();
		for (int i = 0; i < 60; i++) begin
			send_random_word($urandom_range(0, 9) != 0);
		end
	endtask

	// Arbitrary bytes, which are mostly unmapped; an unmapped byte must draw nothing.
	task automatic test_random_noise();
		for (int i = 0; i < 30; i++) begin
			send_random_word(1'b0);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		char_code = '0;
		origin_x  = '0;
		origin_y  = '0;
		colour    = '0;
		scale     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_glyphs();
		test_back_to_back();
		test_random_text();
		test_random_noise();

		wait_for_squares();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_squares.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
